[design/dtu_pkg.sv]
// Shared types and constants for the decimal text to unsigned number checker.
package dtu_pkg;

	localparam int VALUE_W      = 63;
	localparam int CHAR_W       = 8;
	localparam int OFFSET_W     = 8;
	localparam int ECHARS_W     = 32;
	localparam int ECOUNT_W     = 3;
	localparam int ENDING_SLOTS = 4;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	// character codes
	localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] ASCII_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_0     = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_9     = 8'h39;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_VALUE    = 2'd0,
		REG_ENDING_CHARS = 2'd1,
		REG_ENDING_COUNT = 2'd2
	} cfg_reg_t;

	// state of one string as it stands after its final character
	typedef struct packed {
		logic                ended;
		logic                minus;
		logic                overflowed;
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] stop;
	} snapshot_t;

endpackage

[design/decimal_text_to_uint_checker.sv]
// Top level: input register, configuration registers, parser and result stage.
// Pipeline: the final character word passes the input register, then the parse snapshot
//   register, then the result register, before the result word is valid.
// Throughput: one character word per cycle while in_stall is low; the digit accumulate
//   (shift-and-add times ten, overflow test) is the longest input-to-snapshot path.
// Reset: arst_n clears the parse state and the pipeline valids, and sets max_value to
//   2^63-1 with no ending characters in use; no clearing pass is needed.
module decimal_text_to_uint_checker #(
	parameter int POSITION_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [dtu_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dtu_pkg::VALUE_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dtu_pkg::CHAR_W-1:0]           char_code,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	output logic [dtu_pkg::VALUE_W-1:0]          number,
	output logic [dtu_pkg::OFFSET_W-1:0]         end_offset
);

	// configuration registers
	logic [dtu_pkg::VALUE_W-1:0]   max_value_q;
	logic [dtu_pkg::ECHARS_W-1:0]  ending_chars_q;
	logic [dtu_pkg::ECOUNT_W-1:0]  ending_count_q;

	// input register stage
	logic                          valid_s1;
	logic [dtu_pkg::CHAR_W-1:0]    char_s1;
	logic                          last_s1;

	dtu_pkg::snapshot_t            snap;
	logic                          snap_ready;
	logic                          fire_s1;
	logic                          ready_s1;

	// A character that does not end the string never waits on the result side;
	// only the final word of a string needs room in the snapshot register.
	assign fire_s1  = valid_s1 && (!last_s1 || snap_ready);
	assign ready_s1 = !valid_s1 || fire_s1;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q    <= dtu_pkg::VALUE_MAX;
			ending_chars_q <= '0;
			ending_count_q <= '0;
		end else if (cfg_write) begin
			unique case (dtu_pkg::cfg_reg_t'(cfg_index))
				dtu_pkg::REG_MAX_VALUE:    max_value_q    <= cfg_data;
				dtu_pkg::REG_ENDING_CHARS: ending_chars_q <= cfg_data[dtu_pkg::ECHARS_W-1:0];
				dtu_pkg::REG_ENDING_COUNT: ending_count_q <= cfg_data[dtu_pkg::ECOUNT_W-1:0];
				default: begin
					// drop writes to unused indexes
					ending_count_q <= ending_count_q;
				end
			endcase
		end
	end

	// hold the input word until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	dtu_parse #(
		.POSITION_BITS (POSITION_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (fire_s1),
		.char_code    (char_s1),
		.last         (last_s1),
		.ending_chars (ending_chars_q),
		.ending_count (ending_count_q),
		.snap         (snap)
	);

	// only the final word of a string produces a snapshot
	dtu_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (valid_s1 && last_s1),
		.snap       (snap),
		.snap_ready (snap_ready),
		.max_value  (max_value_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.number     (number),
		.end_offset (end_offset)
	);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1))
		else $error("input stalled while the input register can drain");

endmodule

[design/dtu_parse.sv]
// Character parser: phase tracking, digit accumulation and position counting.
module dtu_parse #(
	parameter int POSITION_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic [dtu_pkg::CHAR_W-1:0]           char_code,
	input  logic                                 last,
	input  logic [dtu_pkg::ECHARS_W-1:0]         ending_chars,
	input  logic [dtu_pkg::ECOUNT_W-1:0]         ending_count,
	output dtu_pkg::snapshot_t                   snap
);

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGITS,
		PH_ENDED,
		PH_REJECT
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic                            minus_q, minus_d;
	logic [dtu_pkg::VALUE_W-1:0]     acc_q, acc_d;
	logic                            ovf_q, ovf_d;
	logic [POSITION_BITS-1:0]        pos_q, pos_d;
	logic [POSITION_BITS-1:0]        stop_q, stop_d;
	logic [POSITION_BITS+7:0]        stop_ext;
	logic [dtu_pkg::VALUE_W+3:0]     sum;
	logic [dtu_pkg::ECOUNT_W-1:0]    slots;
	logic                            is_digit, is_space, is_end_char, take_digit;

	always_comb begin
		is_digit = (char_code >= dtu_pkg::ASCII_0) && (char_code <= dtu_pkg::ASCII_9);
		is_space = (char_code == dtu_pkg::ASCII_SPACE) ||
			((char_code >= dtu_pkg::ASCII_TAB) && (char_code <= dtu_pkg::ASCII_CR));

		// counts above the slot number act as all slots
		slots = (ending_count > dtu_pkg::ECOUNT_W'(dtu_pkg::ENDING_SLOTS)) ?
			dtu_pkg::ECOUNT_W'(dtu_pkg::ENDING_SLOTS) : ending_count;
		is_end_char = 1'b0;
		for (int i = 0; i < dtu_pkg::ENDING_SLOTS; i++) begin
			if ((dtu_pkg::ECOUNT_W'(i) < slots) && (ending_chars[8*i +: 8] == char_code))
				is_end_char = 1'b1;
		end

		// times ten plus digit as shift and add; any carry above the value width overflows
		sum = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) +
			{{(dtu_pkg::VALUE_W){1'b0}}, char_code[3:0]};

		phase_d    = phase_q;
		minus_d    = minus_q;
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		stop_d     = stop_q;
		take_digit = 1'b0;

		unique case (phase_q)
			PH_SPACE: begin
				if (is_space) begin
					phase_d = PH_SPACE;
				end else if ((char_code == dtu_pkg::ASCII_PLUS) ||
					(char_code == dtu_pkg::ASCII_MINUS)) begin
					minus_d = (char_code == dtu_pkg::ASCII_MINUS);
					phase_d = PH_SIGN;
				end else if (is_digit) begin
					take_digit = 1'b1;
					phase_d    = PH_DIGITS;
				end else begin
					phase_d = PH_REJECT;
				end
			end
			PH_SIGN: begin
				if (is_digit) begin
					take_digit = 1'b1;
					phase_d    = PH_DIGITS;
				end else begin
					phase_d = PH_REJECT;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					take_digit = 1'b1;
				end else begin
					stop_d  = pos_q;
					phase_d = ((char_code == dtu_pkg::ASCII_NUL) || is_end_char) ?
						PH_ENDED : PH_REJECT;
				end
			end
			PH_ENDED, PH_REJECT: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_REJECT;
			end
		endcase

		if (take_digit && !ovf_q) begin
			if (|sum[dtu_pkg::VALUE_W+3:dtu_pkg::VALUE_W]) begin
				ovf_d = 1'b1;
				acc_d = dtu_pkg::VALUE_MAX;
			end else begin
				acc_d = sum[dtu_pkg::VALUE_W-1:0];
			end
		end

		// saturate the position counter
		pos_d = (&pos_q) ? pos_q : pos_q + 1'b1;

		// a final word inside the digits ends the string there
		if (last && (phase_d == PH_DIGITS)) begin
			stop_d  = pos_d;
			phase_d = PH_ENDED;
		end

		stop_ext        = {8'd0, stop_d};
		snap.ended      = (phase_d == PH_ENDED);
		snap.minus      = minus_d;
		snap.overflowed = ovf_d;
		snap.value      = acc_d;
		snap.stop       = stop_ext[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			minus_q <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			stop_q  <= '0;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_SPACE;
				minus_q <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				pos_q   <= '0;
				stop_q  <= '0;
			end else begin
				phase_q <= phase_d;
				minus_q <= minus_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				pos_q   <= pos_d;
				stop_q  <= stop_d;
			end
		end
	end

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (acc_q == dtu_pkg::VALUE_MAX))
		else $error("overflow flag set without saturated value");

	a_space_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SPACE) |-> ((acc_q == '0) && !minus_q && !ovf_q))
		else $error("whitespace phase with leftover number state");

endmodule

[design/dtu_check.sv]
// Limit check and result register with its output handshake.
module dtu_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            snap_valid,
	input  dtu_pkg::snapshot_t              snap,
	output logic                            snap_ready,
	input  logic [dtu_pkg::VALUE_W-1:0]     max_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            accepted,
	output logic [dtu_pkg::VALUE_W-1:0]     number,
	output logic [dtu_pkg::OFFSET_W-1:0]    end_offset
);

	dtu_pkg::snapshot_t snap_s2;
	logic               valid_s2;
	logic               out_ready;
	logic               ok;

	assign out_ready  = !out_valid || !out_stall;
	assign snap_ready = !valid_s2 || out_ready;

	always_comb begin
		ok = snap_s2.ended && !snap_s2.overflowed &&
			!(snap_s2.minus && (snap_s2.value != '0)) &&
			(snap_s2.value <= max_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (snap_ready)
				valid_s2 <= snap_valid;
			if (out_ready)
				out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid)
			snap_s2 <= snap;
		if (out_ready && valid_s2) begin
			accepted   <= ok;
			number     <= ok ? snap_s2.value : '0;
			end_offset <= ok ? snap_s2.stop : '0;
		end
	end

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> ((number == '0) && (end_offset == '0)))
		else $error("rejected word carries a value or offset");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (number <= max_value))
		else $error("accepted value above the limit");

endmodule

[tb/tb_decimal_text_to_uint_checker.sv]
// Self-checking testbench for decimal_text_to_uint_checker: directed table, then random text.
module tb_decimal_text_to_uint_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_BITS      = 8;
	// the result word passes the snapshot and result registers after the final word is taken
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 24;
	localparam int PHASES        = 5;
	localparam int REPORT_LIMIT  = 10;
	localparam int GAP_ODDS      = 5;
	localparam int MAX_BURST     = 16;

	// parse progress of the text currently arriving
	typedef enum logic [2:0] {
		TP_BLANKS,
		TP_SIGN,
		TP_DIGITS,
		TP_DONE,
		TP_BAD
	} text_phase_t;

	typedef enum logic [1:0] {
		TK_NUMBER,
		TK_BOUNDARY,
		TK_NOISE,
		TK_LONG
	} text_kind_t;

	typedef enum logic {
		ROW_CHAR,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		logic                         ok;
		logic [dtu_pkg::VALUE_W-1:0]  num;
		logic [dtu_pkg::OFFSET_W-1:0] off;
	} verdict_t;

	// one line of the directed table: a character word or a register write
	typedef struct packed {
		row_kind_t                   kind;
		logic [dtu_pkg::CHAR_W-1:0]  ch;
		logic                        lst;
		logic                        typed;
		verdict_t                    want;
		dtu_pkg::cfg_reg_t           sel;
		logic [dtu_pkg::VALUE_W-1:0] data;
	} row_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         cfg_write  = 1'b0;
	dtu_pkg::cfg_reg_t            cfg_index  = dtu_pkg::REG_MAX_VALUE;
	logic [dtu_pkg::VALUE_W-1:0]  cfg_data   = '0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic [dtu_pkg::CHAR_W-1:0]   char_code  = '0;
	logic                         last       = 1'b0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic                         accepted;
	logic [dtu_pkg::VALUE_W-1:0]  number;
	logic [dtu_pkg::OFFSET_W-1:0] end_offset;

	// register copies, reset values as the block has them
	logic [dtu_pkg::VALUE_W-1:0]  lim_value  = dtu_pkg::VALUE_MAX;
	logic [dtu_pkg::ECHARS_W-1:0] end_chars  = '0;
	logic [dtu_pkg::ECOUNT_W-1:0] end_count  = '0;

	// parse state of the current text
	text_phase_t                  txt_phase  = TP_BLANKS;
	logic                         minus_seen = 1'b0;
	logic [dtu_pkg::VALUE_W-1:0]  acc        = '0;
	logic                         acc_ovf    = 1'b0;
	logic [POS_BITS-1:0]          char_pos   = '0;
	logic [POS_BITS-1:0]          stop_pos   = '0;

	verdict_t                     expected_verdicts[$];
	row_t                         directed_rows[$];
	logic [dtu_pkg::CHAR_W-1:0]   text_buf[$];
	bit                           send_idle  = 1'b1;
	bit                           stall_idle = 1'b1;
	int unsigned                  mismatches = 0;
	int unsigned                  stall_left = 0;

	decimal_text_to_uint_checker #(
		.POSITION_BITS(POS_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.number    (number),
		.end_offset(end_offset)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_blank(logic [dtu_pkg::CHAR_W-1:0] c);
		return c == dtu_pkg::ASCII_SPACE ||
			(c >= dtu_pkg::ASCII_TAB && c <= dtu_pkg::ASCII_CR);
	endfunction

	// only the first ending_count bytes are live, and a count above four means four
	function automatic bit is_terminator(logic [dtu_pkg::CHAR_W-1:0] c);
		int n;
		n = (end_count > dtu_pkg::ENDING_SLOTS) ? dtu_pkg::ENDING_SLOTS : int'(end_count);
		for (int i = 0; i < n; i++)
			if (end_chars[dtu_pkg::CHAR_W*i +: dtu_pkg::CHAR_W] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic restart_text();
		txt_phase  = TP_BLANKS;
		minus_seen = 1'b0;
		acc        = '0;
		acc_ovf    = 1'b0;
		char_pos   = '0;
		stop_pos   = '0;
	endtask

	// accumulate one decimal digit; once past the top the value pins and the flag sticks
	task automatic take_digit(input logic [dtu_pkg::CHAR_W-1:0] c);
		logic [dtu_pkg::VALUE_W-1:0] d;
		d = dtu_pkg::VALUE_W'(c - dtu_pkg::ASCII_0);
		if (!acc_ovf) begin
			if (acc > (dtu_pkg::VALUE_MAX - d) / 10) begin
				acc_ovf = 1'b1;
				acc     = dtu_pkg::VALUE_MAX;
			end else begin
				acc = acc * 10 + d;
			end
		end
	endtask

	// advance the parse by one character word; a word marked last yields a verdict
	task automatic predict_word(input logic [dtu_pkg::CHAR_W-1:0] c, input logic lst,
			output bit has_verdict, output verdict_t v);
		bit                  digit;
		bit                  ok;
		logic [POS_BITS-1:0] pos;
		digit       = c >= dtu_pkg::ASCII_0 && c <= dtu_pkg::ASCII_9;
		pos         = char_pos;
		has_verdict = 1'b0;
		v           = '0;
		case (txt_phase)
			TP_BLANKS: begin
				if (c == dtu_pkg::ASCII_PLUS || c == dtu_pkg::ASCII_MINUS) begin
					minus_seen = c == dtu_pkg::ASCII_MINUS;
					txt_phase  = TP_SIGN;
				end else if (digit) begin
					take_digit(c);
					txt_phase = TP_DIGITS;
				end else if (!is_blank(c)) begin
					txt_phase = TP_BAD;
				end
			end
			TP_SIGN: begin
				if (digit) begin
					take_digit(c);
					txt_phase = TP_DIGITS;
				end else begin
					txt_phase = TP_BAD;
				end
			end
			TP_DIGITS: begin
				if (digit) begin
					take_digit(c);
				end else begin
					stop_pos  = pos;
					txt_phase = (c == dtu_pkg::ASCII_NUL || is_terminator(c)) ?
						TP_DONE : TP_BAD;
				end
			end
			default: ;
		endcase
		// the position counter pins at its top value on long texts
		if (char_pos != {POS_BITS{1'b1}})
			char_pos++;
		if (lst) begin
			if (txt_phase == TP_DIGITS) begin
				stop_pos  = char_pos;
				txt_phase = TP_DONE;
			end
			// minus zero passes, any other negative value fails
			ok = txt_phase == TP_DONE && !acc_ovf && !(minus_seen && acc != 0) &&
				acc <= lim_value;
			has_verdict = 1'b1;
			v.ok  = ok;
			v.num = ok ? acc : '0;
			v.off = ok ? dtu_pkg::OFFSET_W'(stop_pos) : '0;
			restart_text();
		end
	endtask

	// present one character word, hold it until taken, then log what it should produce
	task automatic send_word(input logic [dtu_pkg::CHAR_W-1:0] c, input logic lst,
			input bit typed, input verdict_t want);
		bit       has_verdict;
		verdict_t v;
		if (send_idle && $urandom_range(GAP_ODDS - 1, 0) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(MAX_BURST, 1)) @(posedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		char_code <= c;
		last      <= lst;
		do @(posedge clk); while (in_stall);
		predict_word(c, lst, has_verdict, v);
		// a typed row overrides the computed verdict, the parse state still advances
		if (has_verdict)
			expected_verdicts.push_back(typed ? want : v);
	endtask

	// drop valid, let every outstanding verdict drain, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input dtu_pkg::cfg_reg_t sel,
			input logic [dtu_pkg::VALUE_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (sel)
			dtu_pkg::REG_MAX_VALUE:    lim_value = data;
			dtu_pkg::REG_ENDING_CHARS: end_chars = data[dtu_pkg::ECHARS_W-1:0];
			dtu_pkg::REG_ENDING_COUNT: end_count = data[dtu_pkg::ECOUNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic void row_char(logic [dtu_pkg::CHAR_W-1:0] c);
		row_t r;
		r      = '0;
		r.kind = ROW_CHAR;
		r.ch   = c;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_last(logic [dtu_pkg::CHAR_W-1:0] c, logic ok,
			logic [dtu_pkg::VALUE_W-1:0] num, logic [dtu_pkg::OFFSET_W-1:0] off);
		row_t r;
		r          = '0;
		r.kind     = ROW_CHAR;
		r.ch       = c;
		r.lst      = 1'b1;
		r.typed    = 1'b1;
		r.want.ok  = ok;
		r.want.num = num;
		r.want.off = off;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_reg(dtu_pkg::cfg_reg_t sel, logic [dtu_pkg::VALUE_W-1:0] data);
		row_t r;
		r      = '0;
		r.kind = ROW_REG;
		r.sel  = sel;
		r.data = data;
		directed_rows.push_back(r);
	endfunction

	// build one text in text_buf; returns the words that can still change the verdict
	function automatic int compose_text(text_kind_t kind);
		int                         n;
		int                         r;
		int                         body;
		int                         useful;
		logic [63:0]                v;
		logic [dtu_pkg::CHAR_W-1:0] digits[$];
		text_buf.delete();
		if (kind == TK_NOISE) begin
			repeat ($urandom_range(6, 1)) text_buf.push_back(dtu_pkg::CHAR_W'($urandom));
			return text_buf.size();
		end
		// leading blanks: a long run on long texts to push the position past its top
		if (kind == TK_LONG)
			n = $urandom_range(264, 258);
		else
			n = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(5, 0);
			text_buf.push_back((r == 5) ? dtu_pkg::ASCII_SPACE :
				dtu_pkg::ASCII_TAB + dtu_pkg::CHAR_W'(r));
		end
		case ($urandom_range(5, 0))
			0: text_buf.push_back(dtu_pkg::ASCII_PLUS);
			1: text_buf.push_back(dtu_pkg::ASCII_MINUS);
			default: ;
		endcase
		if (kind == TK_BOUNDARY) begin
			// values on either side of the top and of the configured limit
			case ($urandom_range(5, 0))
				0: v = {1'b0, dtu_pkg::VALUE_MAX};
				1: v = {1'b0, dtu_pkg::VALUE_MAX} + 1;
				2: v = {1'b0, lim_value};
				3: v = {1'b0, lim_value} + 1;
				4: v = {$urandom, $urandom} >> $urandom_range(63, 0);
				default: v = '1;
			endcase
			repeat (($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0)
				text_buf.push_back(dtu_pkg::ASCII_0);
			do begin
				digits.push_front(dtu_pkg::ASCII_0 + dtu_pkg::CHAR_W'(v % 10));
				v = v / 10;
			end while (v != 0);
			foreach (digits[i])
				text_buf.push_back(digits[i]);
		end else begin
			n = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
			repeat (n)
				text_buf.push_back(dtu_pkg::ASCII_0 + dtu_pkg::CHAR_W'($urandom_range(9, 0)));
			// now and then break the text somewhere inside
			if (kind == TK_NUMBER && $urandom_range(9, 0) == 0)
				text_buf[$urandom_range(text_buf.size() - 1, 0)] = dtu_pkg::CHAR_W'($urandom);
		end
		body = text_buf.size();
		case ($urandom_range(5, 0))
			0, 1: ;
			2: text_buf.push_back(dtu_pkg::ASCII_NUL);
			3, 4: begin
				n = $urandom_range(3, 0);
				text_buf.push_back(end_chars[dtu_pkg::CHAR_W*n +: dtu_pkg::CHAR_W]);
			end
			default: text_buf.push_back(dtu_pkg::CHAR_W'($urandom));
		endcase
		useful = text_buf.size();
		// trailing words after an end character are ignored by the block
		if (useful > body)
			repeat ($urandom_range(3, 0)) text_buf.push_back(dtu_pkg::CHAR_W'($urandom));
		return useful;
	endfunction

	// receiver back-pressure: random bursts of stalled cycles while stall_idle is set
	always @(negedge clk) begin
		if (!stall_idle) begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(GAP_ODDS - 1, 0) == 0) begin
			stall_left <= $urandom_range(MAX_BURST - 1, 0);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each taken result word with the oldest expected verdict
	// (fields printed as accepted/number/end_offset)
	always @(posedge clk) begin : take_verdict
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result %0b/%0d/%0d", $time,
						accepted, number, end_offset);
			end else begin
				want = expected_verdicts.pop_front();
				if (accepted !== want.ok || number !== want.num || end_offset !== want.off) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: mismatch expected %0b/%0d/%0d got %0b/%0d/%0d", $time,
							want.ok, want.num, want.off, accepted, number, end_offset);
				end
			end
		end
	end

	initial begin
		row_t       r;
		int         sent;
		int         w;
		text_kind_t kind;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, reset register values first
		row_last("0", 1'b1, 0, 1);                              // smallest number
		row_last(dtu_pkg::ASCII_NUL, 1'b0, 0, 0);               // empty text
		row_char(dtu_pkg::ASCII_MINUS);
		row_last("0", 1'b1, 0, 2);                              // minus zero passes
		row_char(dtu_pkg::ASCII_MINUS);
		row_last("5", 1'b0, 0, 0);                              // negative fails
		row_char(dtu_pkg::ASCII_SPACE);
		row_char(dtu_pkg::ASCII_CR);
		row_char(dtu_pkg::ASCII_PLUS);
		row_last("7", 1'b1, 7, 4);                              // blanks and plus sign
		row_last(8'hFF, 1'b0, 0, 0);                            // top character code
		row_char(dtu_pkg::ASCII_PLUS);
		row_char(dtu_pkg::ASCII_MINUS);
		row_last("1", 1'b0, 0, 0);                              // second sign
		row_last(dtu_pkg::ASCII_PLUS, 1'b0, 0, 0);              // sign with no digits
		row_char("4");
		row_char("2");
		row_last("x", 1'b0, 0, 0);                              // no end characters in use
		row_char("8");
		row_char(dtu_pkg::ASCII_NUL);
		row_last("z", 1'b1, 8, 1);                              // words after a zero byte ignored
		row_reg(dtu_pkg::REG_MAX_VALUE, 100);
		row_reg(dtu_pkg::REG_ENDING_CHARS, 32'hFF2E_2C3B);
		row_reg(dtu_pkg::REG_ENDING_COUNT, 7);                  // count above four taken as four
		row_char("9");
		row_char("9");
		row_last(8'hFF, 1'b1, 99, 2);                           // fourth end character
		row_char("1");
		row_char("0");
		row_last("1", 1'b0, 0, 0);                              // above the limit

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_REG) begin
				wait_quiet();
				write_reg(r.sel, r.data);
			end else begin
				send_word(r.ch, r.lst, r.typed, r.want);
			end
		end

		// random phases, each under its own register setting; the block is drained first
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_quiet();
			case (ph)
				0: begin
					send_idle  = 1'b1;
					stall_idle = 1'b1;
					write_reg(dtu_pkg::REG_MAX_VALUE, dtu_pkg::VALUE_MAX);
					write_reg(dtu_pkg::REG_ENDING_CHARS, dtu_pkg::VALUE_W'($urandom));
					write_reg(dtu_pkg::REG_ENDING_COUNT, dtu_pkg::ENDING_SLOTS);
				end
				1: begin
					send_idle  = 1'b1;
					stall_idle = 1'b0;
					write_reg(dtu_pkg::REG_MAX_VALUE, 0);
					write_reg(dtu_pkg::REG_ENDING_CHARS, 32'hFFFF_FFFF);
					write_reg(dtu_pkg::REG_ENDING_COUNT, 0);
				end
				2: begin
					send_idle  = 1'b0;
					stall_idle = 1'b1;
					write_reg(dtu_pkg::REG_MAX_VALUE,
						dtu_pkg::VALUE_W'($urandom_range(100000, 0)));
					write_reg(dtu_pkg::REG_ENDING_CHARS, 32'h2E3B_2C20);
					write_reg(dtu_pkg::REG_ENDING_COUNT, 7);
				end
				3: begin
					send_idle  = 1'b1;
					stall_idle = 1'b1;
					write_reg(dtu_pkg::REG_MAX_VALUE, dtu_pkg::VALUE_W'({$urandom, $urandom}));
					write_reg(dtu_pkg::REG_ENDING_CHARS, 0);
					write_reg(dtu_pkg::REG_ENDING_COUNT,
						dtu_pkg::VALUE_W'($urandom_range(7, 0)));
				end
				default: begin
					// closing stretch runs flat out on both sides
					send_idle  = 1'b0;
					stall_idle = 1'b0;
					write_reg(dtu_pkg::REG_MAX_VALUE,
						dtu_pkg::VALUE_MAX >> $urandom_range(62, 0));
					write_reg(dtu_pkg::REG_ENDING_CHARS, dtu_pkg::VALUE_W'($urandom));
					write_reg(dtu_pkg::REG_ENDING_COUNT,
						dtu_pkg::VALUE_W'($urandom_range(4, 1)));
				end
			endcase
			sent = 0;
			for (int s = 0; sent < PHASE_WORDS; s++) begin
				if (s == 0 && ph == 0) begin
					kind = TK_LONG;
				end else begin
					w    = $urandom_range(99, 0);
					kind = (w < 70) ? TK_NUMBER : (w < 85) ? TK_BOUNDARY : TK_NOISE;
				end
				// hold the sender once mid-phase until every verdict is back
				if (ph == 3 && s == 2)
					wait_quiet();
				sent += compose_text(kind);
				foreach (text_buf[i])
					send_word(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
			end
		end

		wait_quiet();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
